/* design/bma_pkg.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// bma_pkg: shared types and constants for the battery monitor alarm unit
// Request payloads, register indexes, reset values and alarm stage codes.
// ---------------------------------------------------------------------------
package bma_pkg;

  localparam int MV_W      = 14;
  localparam int CFG_IDX_W = 3;
  localparam int STAGE_W   = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BASE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FULL     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WARN     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CUTOFF   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RECHARGE = 3'd4;

  // Register reset values (mV)
  localparam logic [MV_W-1:0] BASE_RST   = 14'd11500;
  localparam logic [MV_W-1:0] FULL_RST   = 14'd12600;
  localparam logic [MV_W-1:0] WARN_RST   = 14'd10500;
  localparam logic [MV_W-1:0] CUTOFF_RST = 14'd10000;

  // Alarm stage codes
  localparam logic [STAGE_W-1:0] STAGE_NONE = 2'd0;
  localparam logic [STAGE_W-1:0] STAGE_HIT  = 2'd1;
  localparam logic [STAGE_W-1:0] STAGE_DONE = 2'd2;

  typedef struct packed {
    logic [MV_W-1:0] reading_mv;
    logic            beacon_seen;
  } in_item_t;

  typedef struct packed {
    logic [MV_W-1:0]    filtered_mv;
    logic               buzzer_on;
    logic               recharge_allowed;
    logic [STAGE_W-1:0] warn_stage;
    logic [STAGE_W-1:0] cutoff_stage;
  } out_item_t;

endpackage

`default_nettype wire

/* design/battery_monitor_alarm_unit.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// battery_monitor_alarm_unit: moving-average battery filter with two-stage
// low-voltage alarm, buzzer pulse and sticky recharge latch.
// ---------------------------------------------------------------------------
// Stages: window RAM read, sum update + write-back, reciprocal multiply and
//   alarm logic. Throughput: one request per cycle while in_stall is low; the
//   window RAM takes one read and one write per cycle and the write of a
//   request lands before its entry is reused.
// Reset (sync, rst_n low): registers to defaults, pipeline and output queue
//   empty, alarms idle. The window RAM is not swept: until the write pointer
//   completes its first lap, old samples read as base_mv captured at the
//   first request.
module battery_monitor_alarm_unit #(
  parameter int WINDOW_LEN = 100,
  parameter int BUZZ_LEN   = 5
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  // input requests
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire bma_pkg::in_item_t                  in_data,
  // results
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output bma_pkg::out_item_t                      out_data,
  // configuration writes
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [bma_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [bma_pkg::MV_W-1:0]           cfg_data
);

  localparam int MV_W    = bma_pkg::MV_W;
  localparam int PTR_W   = $clog2(WINDOW_LEN);
  // Sum of WINDOW_LEN 14-bit samples
  localparam int SUM_W   = PTR_W + MV_W;
  // Exact divide by WINDOW_LEN: avg = (sum * RECIP) >> SHIFT for every sum
  // below 2^SUM_W, since the reciprocal error times the sum stays under 2^SHIFT.
  localparam int SHIFT   = 2 * PTR_W + MV_W;
  localparam int RCP_W   = SUM_W + 1;
  localparam int PROD_W  = SUM_W + RCP_W;
  localparam logic [RCP_W-1:0] RECIP =
    RCP_W'(((64'd1 << SHIFT) + 64'(WINDOW_LEN - 1)) / 64'(WINDOW_LEN));
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(WINDOW_LEN - 1);
  localparam int BZ_W    = $clog2(BUZZ_LEN + 1);
  localparam logic [BZ_W-1:0] BUZZ_END = BZ_W'(BUZZ_LEN);
  // Output queue: deep enough to hold every request in flight
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int CRED_W     = FIFO_AW + 2;

  // ---------------- configuration registers ----------------
  logic [MV_W-1:0] base_r, full_r, warn_r, cut_r;
  logic            rch_present_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r        <= bma_pkg::BASE_RST;
      full_r        <= bma_pkg::FULL_RST;
      warn_r        <= bma_pkg::WARN_RST;
      cut_r         <= bma_pkg::CUTOFF_RST;
      rch_present_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        bma_pkg::REG_BASE:     base_r        <= cfg_data;
        bma_pkg::REG_FULL:     full_r        <= cfg_data;
        bma_pkg::REG_WARN:     warn_r        <= cfg_data;
        bma_pkg::REG_CUTOFF:   cut_r         <= cfg_data;
        bma_pkg::REG_RECHARGE: rch_present_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // ---------------- stage A: accept, issue window read ----------------
  logic in_acc;
  logic [PTR_W-1:0] ptr_r;
  logic             lap_r;      // pointer has wrapped at least once
  logic             started_r;  // first request seen since reset
  logic [MV_W-1:0]  base_fill_r;

  assign in_acc = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r     <= '0;
      lap_r     <= 1'b0;
      started_r <= 1'b0;
    end else if (in_acc) begin
      started_r <= 1'b1;
      if (ptr_r == PTR_LAST) begin
        ptr_r <= '0;
        lap_r <= 1'b1;
      end else begin
        ptr_r <= ptr_r + PTR_W'(1);
      end
    end
  end

  // base_mv is sampled once, at the first request after reset
  always_ff @(posedge clk) begin
    if (in_acc && !started_r) begin
      base_fill_r <= base_r;
    end
  end

  // ---------------- stage B: old sample in, sum update, write-back --------
  logic                b_valid_r;
  bma_pkg::in_item_t   b_item_r;
  logic                b_fresh_r;   // entry not yet written this lap
  logic [PTR_W-1:0]    b_addr_r;
  logic [MV_W-1:0]     ram_rdata;
  logic [MV_W-1:0]     old_mv;
  logic [SUM_W-1:0]    sum_r, sum_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else begin
      b_valid_r <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      b_item_r  <= in_data;
      b_fresh_r <= !lap_r;
      b_addr_r  <= ptr_r;
    end
  end

  bma_ram #(
    .WIDTH (MV_W),
    .DEPTH (WINDOW_LEN)
  ) u_window (
    .clk   (clk),
    .we    (b_valid_r),
    .waddr (b_addr_r),
    .wdata (b_item_r.reading_mv),
    .re    (in_acc),
    .raddr (ptr_r),
    .rdata (ram_rdata)
  );

  assign old_mv  = b_fresh_r ? base_fill_r : ram_rdata;
  assign sum_nxt = sum_r - SUM_W'(old_mv) + SUM_W'(b_item_r.reading_mv);

  // First request seeds the sum with WINDOW_LEN copies of base_mv; no other
  // request is in flight at that point.
  always_ff @(posedge clk) begin
    if (b_valid_r) begin
      sum_r <= sum_nxt;
    end else if (in_acc && !started_r) begin
      sum_r <= SUM_W'(SUM_W'(base_r) * SUM_W'(WINDOW_LEN));
    end
  end

  // ---------------- stage C: reciprocal multiply ----------------
  logic              c_valid_r, c_beacon_r;
  logic              d_valid_r, d_beacon_r;
  logic [PROD_W-1:0] d_prod_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_valid_r <= 1'b0;
      d_valid_r <= 1'b0;
    end else begin
      c_valid_r <= b_valid_r;
      d_valid_r <= c_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (b_valid_r) begin
      c_beacon_r <= b_item_r.beacon_seen;
    end
    if (c_valid_r) begin
      d_beacon_r <= c_beacon_r;
      d_prod_r   <= PROD_W'(sum_r) * PROD_W'(RECIP);
    end
  end

  // ---------------- stage D: alarm, buzzer, recharge ----------------
  logic [BZ_W-1:0]             buzz_r, buzz_nxt, buzz_start;
  logic [bma_pkg::STAGE_W-1:0] warn_cnt_r, warn_cnt_nxt, warn_aged;
  logic [bma_pkg::STAGE_W-1:0] cut_cnt_r, cut_cnt_nxt, cut_aged;
  logic                        rch_r, rch_nxt;
  logic [MV_W-1:0]             avg_mv, filt_mv;
  bma_pkg::out_item_t          res;

  assign avg_mv = d_prod_r[SHIFT +: MV_W];

  always_comb begin
    // a stage that just hit restarts the buzzer pulse
    if (warn_cnt_r == bma_pkg::STAGE_HIT || cut_cnt_r == bma_pkg::STAGE_HIT) begin
      buzz_start = '0;
    end else begin
      buzz_start = buzz_r;
    end
    buzz_nxt = (buzz_start < BUZZ_END) ? buzz_start + BZ_W'(1) : buzz_start;

    rch_nxt = rch_r | (rch_present_r & (avg_mv < cut_r) & d_beacon_r);

    warn_aged = (warn_cnt_r == bma_pkg::STAGE_HIT) ? bma_pkg::STAGE_DONE : warn_cnt_r;
    cut_aged  = (cut_cnt_r == bma_pkg::STAGE_HIT) ? bma_pkg::STAGE_DONE : cut_cnt_r;

    warn_cnt_nxt = warn_aged;
    cut_cnt_nxt  = cut_aged;
    filt_mv      = avg_mv;
    if (avg_mv >= full_r) begin
      filt_mv = full_r;
    end else if (avg_mv >= cut_r && avg_mv < warn_r && warn_aged < bma_pkg::STAGE_DONE) begin
      warn_cnt_nxt = warn_aged + bma_pkg::STAGE_W'(1);
    end else if (avg_mv < cut_r && cut_aged < bma_pkg::STAGE_DONE) begin
      cut_cnt_nxt = cut_aged + bma_pkg::STAGE_W'(1);
    end

    res.filtered_mv      = filt_mv;
    res.buzzer_on        = (buzz_nxt < BUZZ_END);
    res.recharge_allowed = rch_nxt;
    res.warn_stage       = warn_cnt_nxt;
    res.cutoff_stage     = cut_cnt_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buzz_r     <= BUZZ_END;
      warn_cnt_r <= bma_pkg::STAGE_NONE;
      cut_cnt_r  <= bma_pkg::STAGE_NONE;
      rch_r      <= 1'b0;
    end else if (d_valid_r) begin
      buzz_r     <= buzz_nxt;
      warn_cnt_r <= warn_cnt_nxt;
      cut_cnt_r  <= cut_cnt_nxt;
      rch_r      <= rch_nxt;
    end
  end

  // ---------------- output queue ----------------
  // Input is stalled once queued plus in-flight requests fill the queue,
  // so the pipeline never has to stop.
  bma_pkg::out_item_t fifo_mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [FIFO_AW:0]   cnt_r;
  logic               pop;
  logic [CRED_W-1:0]  credits;

  assign pop       = out_valid && !out_stall;
  assign out_valid = (cnt_r != '0);
  assign out_data  = fifo_mem[rd_ptr_r];
  assign credits   = CRED_W'(cnt_r) + CRED_W'(b_valid_r) + CRED_W'(c_valid_r)
                   + CRED_W'(d_valid_r);
  assign in_stall  = (credits >= CRED_W'(FIFO_DEPTH));

  always_ff @(posedge clk) begin
    if (d_valid_r) begin
      fifo_mem[wr_ptr_r] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (d_valid_r) begin
        wr_ptr_r <= wr_ptr_r + FIFO_AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + FIFO_AW'(1);
      end
      cnt_r <= cnt_r + (FIFO_AW+1)'(d_valid_r) - (FIFO_AW+1)'(pop);
    end
  end

endmodule

`default_nettype wire

/* design/bma_ram.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// bma_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; no reset on contents.
// ---------------------------------------------------------------------------
module bma_ram #(
  parameter int WIDTH = 14,
  parameter int DEPTH = 100
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* design/bma_checker.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// bma_checker: port-level assertions for battery_monitor_alarm_unit
// Watches result hold, reset and origin rules, stage codes and the sticky recharge flag.
// ---------------------------------------------------------------------------
module bma_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_stall,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire bma_pkg::out_item_t out_data
);

  logic any_in_r;     // a request has been accepted since reset
  logic rch_seen_r;   // a result with recharge_allowed was delivered

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      any_in_r   <= 1'b0;
      rch_seen_r <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        any_in_r <= 1'b1;
      end
      if (out_valid && !out_stall && out_data.recharge_allowed) begin
        rch_seen_r <= 1'b1;
      end
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result shown right after reset");

  a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> any_in_r)
    else $error("result without any accepted request");

  a_stage_codes: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |->
      (out_data.warn_stage == bma_pkg::STAGE_NONE ||
       out_data.warn_stage == bma_pkg::STAGE_HIT ||
       out_data.warn_stage == bma_pkg::STAGE_DONE) &&
      (out_data.cutoff_stage == bma_pkg::STAGE_NONE ||
       out_data.cutoff_stage == bma_pkg::STAGE_HIT ||
       out_data.cutoff_stage == bma_pkg::STAGE_DONE))
    else $error("alarm stage out of range");

  a_recharge_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && rch_seen_r |-> out_data.recharge_allowed)
    else $error("recharge flag dropped");

endmodule

bind battery_monitor_alarm_unit bma_checker u_bma_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire

/* dv/tb.sv */
// ---------------------------------------------------------------------------
// tb: self-checking bench for battery_monitor_alarm_unit
// Drives battery readings through the request channel, predicts the status of
// each accepted request, and checks every result field by field. It covers
// threshold and clamp changes between phases, random idling and stalls, and a
// long receiver hold-off.
// ---------------------------------------------------------------------------
module tb;
  import bma_pkg::*;

  localparam int WIN_LEN     = 100;
  localparam int BUZZ_LEN    = 5;
  localparam int MV_MAX      = (1 << MV_W) - 1;
  localparam int NUM_PHASES  = 12;
  localparam int PHASE_REQS  = 166;
  localparam int CALM_PHASE  = 3;    // no idling on either side
  localparam int HOLD_PHASE  = 6;    // receiver holds off while requests pile up
  localparam int HOLD_CYCLES = 120;
  localparam int CYCLE_LIMIT = 100000;
  localparam int MAX_PRINTS  = 30;

  // Index with no register behind it; the block should take the write and
  // ignore it.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

  // Opening requests, with base_mv = 10300 and default thresholds. The first
  // reading lands the average in the warning band. The low readings that
  // follow pull it under the cutoff just after the warning buzzer pulse ends.
  // Beacon is seen with recharge hardware absent, so the latch must stay clear.
  localparam in_item_t OPENING[16] = '{
    '{14'h3FFF, 1'b1}, '{14'h0000, 1'b0}, '{14'h0000, 1'b1}, '{14'h2AAA, 1'b0},
    '{14'h1555, 1'b1}, '{14'h0000, 1'b1}, '{14'h0000, 1'b1}, '{14'h0000, 1'b1},
    '{14'h0000, 1'b0}, '{14'h3FFF, 1'b1}, '{14'h3FFF, 1'b0}, '{14'h0000, 1'b1},
    '{14'h3FFF, 1'b1}, '{14'h0001, 1'b0}, '{14'h0000, 1'b1}, '{14'h0000, 1'b1}
  };

  // -------------------------------------------------------------------------
  // Status predictor and store of expected results
  // -------------------------------------------------------------------------
  class alarm_scoreboard;
    logic [MV_W-1:0]    base_mv, full_mv, warn_mv, cutoff_mv;
    logic               recharge_fitted;
    logic [MV_W-1:0]    window[WIN_LEN];
    logic [20:0]        window_sum;
    int unsigned        oldest;
    logic [3:0]         buzz_ticks;
    logic [STAGE_W-1:0] warn_stage, cutoff_stage;
    logic               buzzer, recharge_latch, primed;
    out_item_t          pending[$];
    int                 errors;
    int                 n_checked;

    function new();
      base_mv         = BASE_RST;
      full_mv         = FULL_RST;
      warn_mv         = WARN_RST;
      cutoff_mv       = CUTOFF_RST;
      recharge_fitted = 1'b0;
      refill(base_mv);
      buzz_ticks      = 4'(BUZZ_LEN);
      warn_stage      = STAGE_NONE;
      cutoff_stage    = STAGE_NONE;
      buzzer          = 1'b0;
      recharge_latch  = 1'b0;
      primed          = 1'b0;
      errors          = 0;
      n_checked       = 0;
    endfunction

    function void refill(logic [MV_W-1:0] v);
      for (int k = 0; k < WIN_LEN; k++) window[k] = v;
      window_sum = 21'(WIN_LEN * v);
      oldest     = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [MV_W-1:0] data);
      case (idx)
        REG_BASE:     base_mv = data;
        REG_FULL:     full_mv = data;
        REG_WARN:     warn_mv = data;
        REG_CUTOFF:   cutoff_mv = data;
        REG_RECHARGE: recharge_fitted = data[0];
        default: ;
      endcase
    endfunction

    task flag_mismatch(string what);
      if (errors < MAX_PRINTS) $display("MISMATCH result %0d: %s", n_checked, what);
      errors++;
    endtask

    // One tick of the filter and alarm logic for an accepted request
    task note_reading(in_item_t req);
      out_item_t       want;
      logic [MV_W-1:0] avg;
      // base_mv is captured by the first request only
      if (!primed) begin
        refill(base_mv);
        primed = 1'b1;
      end
      if (warn_stage == STAGE_HIT || cutoff_stage == STAGE_HIT) buzz_ticks = '0;
      if (buzz_ticks < BUZZ_LEN) buzz_ticks++;
      if (buzz_ticks < BUZZ_LEN) buzzer = 1'b1;
      else if (buzz_ticks == BUZZ_LEN) buzzer = 1'b0;

      window_sum     = window_sum - window[oldest] + req.reading_mv;
      window[oldest] = req.reading_mv;
      oldest         = (oldest == WIN_LEN - 1) ? 0 : oldest + 1;
      avg            = MV_W'(window_sum / WIN_LEN);

      if (recharge_fitted && avg < cutoff_mv && req.beacon_seen) recharge_latch = 1'b1;

      if (warn_stage == STAGE_HIT) warn_stage = STAGE_DONE;
      if (cutoff_stage == STAGE_HIT) cutoff_stage = STAGE_DONE;
      // first matching branch wins, thresholds are not ordered
      if (avg >= full_mv) avg = full_mv;
      else if (cutoff_mv <= avg && avg < warn_mv && warn_stage == STAGE_NONE)
        warn_stage = STAGE_HIT;
      else if (avg < cutoff_mv && cutoff_stage == STAGE_NONE)
        cutoff_stage = STAGE_HIT;

      want.filtered_mv      = avg;
      want.buzzer_on        = buzzer;
      want.recharge_allowed = recharge_latch;
      want.warn_stage       = warn_stage;
      want.cutoff_stage     = cutoff_stage;
      pending.push_back(want);
    endtask

    task check_status(out_item_t got);
      out_item_t want;
      n_checked++;
      if (pending.size() == 0) begin
        flag_mismatch("result with no request outstanding");
        return;
      end
      want = pending.pop_front();
      if (got.filtered_mv !== want.filtered_mv)
        flag_mismatch($sformatf("filtered_mv %0d, expected %0d",
                                got.filtered_mv, want.filtered_mv));
      if (got.buzzer_on !== want.buzzer_on)
        flag_mismatch($sformatf("buzzer_on %b, expected %b", got.buzzer_on, want.buzzer_on));
      if (got.recharge_allowed !== want.recharge_allowed)
        flag_mismatch($sformatf("recharge_allowed %b, expected %b",
                                got.recharge_allowed, want.recharge_allowed));
      if (got.warn_stage !== want.warn_stage)
        flag_mismatch($sformatf("warn_stage %0d, expected %0d",
                                got.warn_stage, want.warn_stage));
      if (got.cutoff_stage !== want.cutoff_stage)
        flag_mismatch($sformatf("cutoff_stage %0d, expected %0d",
                                got.cutoff_stage, want.cutoff_stage));
    endtask
  endclass

  // -------------------------------------------------------------------------
  // Block and its ports
  // -------------------------------------------------------------------------
  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  in_item_t             in_data;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_item_t            out_data;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [MV_W-1:0]      cfg_data;

  battery_monitor_alarm_unit #(
    .WINDOW_LEN (WIN_LEN),
    .BUZZ_LEN   (BUZZ_LEN)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  alarm_scoreboard book;
  int              idle_pct = 15;  // percent of cycles each side idles
  int              hold_req_cnt = 0;
  int              cycles = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("battery_monitor_alarm_unit test failed");
      $finish;
    end
  end

  // Both handshakes are sampled at the rising edge. A request accepted at an
  // edge cannot return a result at that same edge, so the two calls below
  // never race each other.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) book.note_reading(in_data);
      if (out_valid && !out_stall) book.check_status(out_data);
    end
  end

  // Receiver: random stalls, plus a long hold-off each time the stimulus asks
  // for one. The hold-off is counted here so the sender keeps pushing.
  int hold_seen = 0;
  int hold_left = 0;
  always @(negedge clk) begin
    if (hold_seen != hold_req_cnt) begin
      hold_seen = hold_req_cnt;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < idle_pct);
    end
  end

  // -------------------------------------------------------------------------
  // Driver tasks: entered and left at a falling edge
  // -------------------------------------------------------------------------
  task automatic send_reading(input in_item_t req);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [MV_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    book.write_reg(idx, data);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // Sender pauses until every outstanding request has produced its result
  task automatic drain();
    in_valid <= 1'b0;
    while (book.pending.size() != 0) @(negedge clk);
  endtask

  // Threshold pick: extremes a third of the time
  function automatic logic [MV_W-1:0] pick_mv();
    case ($urandom_range(5))
      0:       return '0;
      1:       return MV_W'(MV_MAX);
      default: return MV_W'($urandom_range(MV_MAX));
    endcase
  endfunction

  // -------------------------------------------------------------------------
  // Stimulus
  // -------------------------------------------------------------------------
  initial begin
    in_item_t        req;
    logic [MV_W-1:0] data;
    int              level, run_left, v;
    book      = new();
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_BASE;
    cfg_data  = '0;
    run_left  = 0;
    level     = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Base written before the first request takes effect. Recharge is written
    // with upper bits set and bit 0 clear: hardware absent.
    write_reg(REG_BASE, 14'd10300);
    write_reg(REG_RECHARGE, 14'h3FFE);
    foreach (OPENING[i]) send_reading(OPENING[i]);

    for (int p = 0; p < NUM_PHASES; p++) begin
      drain();
      idle_pct = (p == CALM_PHASE) ? 0 : 15;
      // clamp at both extremes early on, random afterwards
      write_reg(REG_FULL, (p == 0) ? MV_W'(0) : (p == 1) ? MV_W'(MV_MAX) : pick_mv());
      write_reg(REG_WARN, pick_mv());
      write_reg(REG_CUTOFF, pick_mv());
      data    = MV_W'($urandom);
      data[0] = p[0];
      write_reg(REG_RECHARGE, data);
      // base_mv after the first request must change nothing
      if (p % 4 == 1) write_reg(REG_BASE, (p % 8 == 1) ? MV_W'(MV_MAX) : MV_W'(0));
      if (p == 4) write_reg(REG_SPARE, MV_W'($urandom));
      if (p == HOLD_PHASE) hold_req_cnt++;

      // Mostly slow drifts toward a level so the average actually crosses the
      // thresholds; the rest are full-range readings.
      for (int k = 0; k < PHASE_REQS; k++) begin
        if (run_left == 0) begin
          level    = $urandom_range(MV_MAX);
          run_left = $urandom_range(40, 10);
        end
        run_left--;
        if ($urandom_range(9) < 3) begin
          req.reading_mv = MV_W'($urandom);
        end else begin
          v = level + $urandom_range(400) - 200;
          if (v < 0) v = 0;
          if (v > MV_MAX) v = MV_MAX;
          req.reading_mv = MV_W'(v);
        end
        req.beacon_seen = 1'($urandom_range(1));
        send_reading(req);
      end
    end

    drain();
    repeat (10) @(posedge clk);
    if (book.errors == 0) begin
      $display("battery_monitor_alarm_unit test passed");
    end else begin
      $display("battery_monitor_alarm_unit test failed");
    end
    $finish;
  end

endmodule

/* battery_monitor_alarm_unit.f */
design/bma_pkg.sv
design/bma_ram.sv
design/battery_monitor_alarm_unit.sv
design/bma_checker.sv
dv/tb.sv
